>>> design/mge_pkg.sv
// shared types and constants for the mono glyph to rgb565 expander
package mge_pkg;

    // glyph geometry
    localparam int MAX_GLYPH_SIZE = 48;
    localparam int POS_W          = 6;
    localparam int SIZE_W         = 7;
    localparam int BYTE_BITS      = 8;
    localparam int CNT_W          = 3;

    // register widths and reset values
    localparam int COLOR_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [COLOR_W-1:0] FG_COLOR_RST     = 16'hFFFF;
    localparam logic [COLOR_W-1:0] CLEAR_COLOR_RST  = 16'h0000;
    localparam logic [POS_W-1:0]   GLYPH_WIDTH_RST  = 6'd8;
    localparam logic [POS_W-1:0]   GLYPH_HEIGHT_RST = 6'd16;

    // default depth of the byte queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_COLOR     = 2'd0,
        CFG_CLEAR_COLOR  = 2'd1,
        CFG_GLYPH_WIDTH  = 2'd2,
        CFG_GLYPH_HEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] bitmap_byte;
        logic                 new_glyph;
    } src_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic               row_end;
        logic               glyph_end;
        logic               last;
    } pix_item_t;

    // one classified byte: bits to expand, pixel count minus one, end flags
    typedef struct packed {
        logic [BYTE_BITS-1:0] bits;
        logic [CNT_W-1:0]     cnt_m1;
        logic                 row_end;
        logic                 glyph_end;
    } job_t;

endpackage

>>> design/mono_glyph_to_rgb565_expander_unit.sv
// top level of the mono glyph to rgb565 expander
//
//  channel   signals                          direction  transaction when
//  ------    -------------------------------  ---------  -----------------------------
//  src       src_valid, src_stall, src_item   in         src_valid && !src_stall
//  pix       pix_valid, pix_stall, pix_item   out        pix_valid && !pix_stall
//  cfg       cfg_we, cfg_index, cfg_data      in         cfg_we (write only)
//
//  one pixel leaves per cycle while pix_stall is low; a byte yields 1 to 8
//  pixels (min of 8 and columns left in the row); the front end sets this
//  number for each byte it classifies
//  a byte is registered in the queue and the job register, each pixel in pix_reg
//  up to QUEUE_DEPTH classified bytes wait between front and back
//  reset clears position to row 0 column 0, empties the queue and loads the
//  register reset values; src_stall rises only while the queue is full
module mono_glyph_to_rgb565_expander_unit #(
    parameter int QUEUE_DEPTH = mge_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // byte input
    input  logic                              src_valid,
    output logic                              src_stall,
    input  mge_pkg::src_item_t                src_item,
    // pixel output
    output logic                              pix_valid,
    input  logic                              pix_stall,
    output mge_pkg::pix_item_t                pix_item,
    // register writes
    input  logic                              cfg_we,
    input  logic [mge_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mge_pkg::CFG_W-1:0]         cfg_data
);

    // configuration registers
    logic [mge_pkg::COLOR_W-1:0] fg_color_reg;
    logic [mge_pkg::COLOR_W-1:0] clear_color_reg;
    logic [mge_pkg::POS_W-1:0]   glyph_width_reg;
    logic [mge_pkg::POS_W-1:0]   glyph_height_reg;

    // front to queue, queue to back
    logic          src_accept;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    mge_pkg::job_t front_job;
    mge_pkg::job_t q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg     <= mge_pkg::FG_COLOR_RST;
            clear_color_reg  <= mge_pkg::CLEAR_COLOR_RST;
            glyph_width_reg  <= mge_pkg::GLYPH_WIDTH_RST;
            glyph_height_reg <= mge_pkg::GLYPH_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (mge_pkg::cfg_index_t'(cfg_index))
                mge_pkg::CFG_FG_COLOR:     fg_color_reg     <= cfg_data;
                mge_pkg::CFG_CLEAR_COLOR:  clear_color_reg  <= cfg_data;
                mge_pkg::CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[mge_pkg::POS_W-1:0];
                mge_pkg::CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[mge_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // the front takes a byte whenever the queue has room
    assign src_stall  = q_full;
    assign src_accept = src_valid && !q_full;

    // position tracking and per-byte classification
    mge_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (src_accept),
        .item         (src_item),
        .glyph_width  (glyph_width_reg),
        .glyph_height (glyph_height_reg),
        .job          (front_job)
    );

    // decouples byte acceptance from pixel drain
    mge_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (src_accept),
        .push_job  (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (q_job)
    );

    // pixel serializer with output register
    mge_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_avail   (q_not_empty),
        .job_in      (q_job),
        .take        (q_pop),
        .fg_color    (fg_color_reg),
        .clear_color (clear_color_reg),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix_item    (pix_item)
    );

endmodule

>>> design/mge_front.sv
// front end: position tracking and classification of each bitmap byte
module mge_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  mge_pkg::src_item_t           item,
    input  logic [mge_pkg::POS_W-1:0]    glyph_width,
    input  logic [mge_pkg::POS_W-1:0]    glyph_height,
    output mge_pkg::job_t                job
);

    localparam int SW = mge_pkg::SIZE_W;
    localparam logic [SW-1:0] MAX_SZ   = SW'(mge_pkg::MAX_GLYPH_SIZE);
    localparam logic [SW-1:0] ONE      = SW'(1);
    localparam logic [SW-1:0] BYTE_SZ  = SW'(mge_pkg::BYTE_BITS);

    logic [mge_pkg::POS_W-1:0] col_reg, col_next;
    logic [mge_pkg::POS_W-1:0] row_reg, row_next;

    logic [SW-1:0] w_raw, h_raw, w_eff, h_eff;
    logic [SW-1:0] col0, row0, col1, row1, row2, row3, span, span_m1;
    logic          ends;

    always_comb
    begin
        w_raw = {1'b0, glyph_width};
        h_raw = {1'b0, glyph_height};
        // zero counts as one, oversize saturates
        if (w_raw == '0)
            w_eff = ONE;
        else if (w_raw > MAX_SZ)
            w_eff = MAX_SZ;
        else
            w_eff = w_raw;
        if (h_raw == '0)
            h_eff = ONE;
        else if (h_raw > MAX_SZ)
            h_eff = MAX_SZ;
        else
            h_eff = h_raw;

        col0 = item.new_glyph ? '0 : {1'b0, col_reg};
        row0 = item.new_glyph ? '0 : {1'b0, row_reg};

        // position left outside a shrunk glyph starts the next row
        if (col0 >= w_eff)
        begin
            col1 = '0;
            row1 = row0 + ONE;
        end
        else
        begin
            col1 = col0;
            row1 = row0;
        end
        row2 = (row1 >= h_eff) ? '0 : row1;

        span    = w_eff - col1;
        span_m1 = span - ONE;
        ends    = (span <= BYTE_SZ);

        job.bits      = item.bitmap_byte;
        job.cnt_m1    = ends ? span_m1[mge_pkg::CNT_W-1:0] : '1;
        job.row_end   = ends;
        job.glyph_end = ends && (row2 == h_eff - ONE);

        row3 = row2 + ONE;
        if (ends)
        begin
            col_next = '0;
            row_next = (row3 >= h_eff) ? '0 : row3[mge_pkg::POS_W-1:0];
        end
        else
        begin
            col_next = 6'(col1 + BYTE_SZ);
            row_next = row2[mge_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_glyph_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        job.glyph_end |-> job.row_end)
        else $error("glyph end without row end");

    a_wrap_after_glyph_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && job.glyph_end |=> col_reg == '0 && row_reg == '0)
        else $error("position did not wrap at glyph end");

    a_full_byte_inside_row: assert property (@(posedge clk) disable iff (!rst_n)
        !job.row_end |-> job.cnt_m1 == '1)
        else $error("short byte away from row end");

endmodule

>>> design/mge_queue.sv
// small fifo of classified bytes between front and back
module mge_queue #(
    parameter int DEPTH = mge_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mge_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output mge_pkg::job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mge_pkg::job_t      mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign pop_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

>>> design/mge_back.sv
// back end: serializes one classified byte into pixels, one per cycle while pix_stall is low
module mge_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_avail,
    input  mge_pkg::job_t                  job_in,
    output logic                           take,
    input  logic [mge_pkg::COLOR_W-1:0]    fg_color,
    input  logic [mge_pkg::COLOR_W-1:0]    clear_color,
    output logic                           pix_valid,
    input  logic                           pix_stall,
    output mge_pkg::pix_item_t             pix_item
);

    localparam int BB = mge_pkg::BYTE_BITS;

    logic                     job_valid_reg, job_valid_next;
    logic [BB-1:0]            bits_reg, bits_next;
    logic [mge_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic                     rend_reg, rend_next;
    logic                     gend_reg, gend_next;
    logic                     pix_valid_reg, pix_valid_next;
    mge_pkg::pix_item_t       pix_reg, pix_next;

    logic out_adv, emit, finish, is_last;

    always_comb
    begin
        out_adv = !pix_valid_reg || !pix_stall;
        emit    = job_valid_reg && out_adv;
        is_last = (rem_reg == '0);
        finish  = emit && is_last;
        take    = job_avail && (!job_valid_reg || finish);

        job_valid_next = take ? 1'b1 : (finish ? 1'b0 : job_valid_reg);
        bits_next      = bits_reg;
        rem_next       = rem_reg;
        rend_next      = rend_reg;
        gend_next      = gend_reg;
        if (take)
        begin
            bits_next = job_in.bits;
            rem_next  = job_in.cnt_m1;
            rend_next = job_in.row_end;
            gend_next = job_in.glyph_end;
        end
        else if (emit)
        begin
            bits_next = {bits_reg[BB-2:0], 1'b0};
            rem_next  = rem_reg - mge_pkg::CNT_W'(1);
        end

        pix_valid_next = out_adv ? emit : pix_valid_reg;
        pix_next       = pix_reg;
        if (emit)
        begin
            pix_next.pixel     = bits_reg[BB-1] ? fg_color : clear_color;
            pix_next.last      = is_last;
            pix_next.row_end   = is_last && rend_reg;
            pix_next.glyph_end = is_last && gend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        rem_reg  <= rem_next;
        rend_reg <= rend_next;
        gend_reg <= gend_next;
        pix_reg  <= pix_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pix_item  = pix_reg;

    a_row_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && pix_reg.row_end |-> pix_reg.last)
        else $error("row end on a pixel that is not last of its byte");

    a_glyph_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && pix_reg.glyph_end |-> pix_reg.row_end)
        else $error("glyph end without row end");

    a_take_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        take && job_valid_reg |-> finish)
        else $error("new byte loaded over unfinished byte");

endmodule
